/* rtl/ccm_pkg.sv */
// Shared types and constants for the cluster centroid moment core.
// No dependencies; used by every file in rtl/.
package ccm_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int ESUM_W = 22;
    localparam int WSUM_W = 38;

    // shared divider: numerator, divisor and quotient widths
    localparam int NUM_W = 52;
    localparam int DEN_W = 40;
    localparam int QUO_W = 17;

    localparam int FRAC_BITS   = 12;
    localparam int ROUND_SHIFT = FRAC_BITS + 1;
    localparam int ROW_LIMIT   = 68;
    localparam int BIN_LIMIT   = 16;

    localparam logic [2:0] REG_X_LOW         = 3'd0;
    localparam logic [2:0] REG_X_HIGH        = 3'd1;
    localparam logic [2:0] REG_Y_LOW         = 3'd2;
    localparam logic [2:0] REG_Y_HIGH        = 3'd3;
    localparam logic [2:0] REG_X_BIN_COUNT   = 3'd4;
    localparam logic [2:0] REG_Y_BIN_COUNT   = 3'd5;
    localparam logic [2:0] REG_BLOCK_WIDTH_X = 3'd6;
    localparam logic [2:0] REG_BLOCK_WIDTH_Y = 3'd7;

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_ZERO   = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    typedef struct packed {
        logic [15:0]        hit_energy;
        logic signed [15:0] hit_x;
        logic signed [15:0] hit_y;
        logic [6:0]         hit_row;
        logic               last_hit;
    } hit_t;

    typedef struct packed {
        logic [7:0]         cell_bin;
        logic signed [15:0] x_moment;
        logic signed [15:0] y_moment;
        logic [1:0]         status;
    } result_t;

    typedef struct packed {
        logic signed [15:0] x_low;
        logic signed [15:0] x_high;
        logic signed [15:0] y_low;
        logic signed [15:0] y_high;
        logic [4:0]         x_bin_count;
        logic [4:0]         y_bin_count;
        logic [15:0]        block_width_x;
        logic [15:0]        block_width_y;
    } cfg_t;

    // finished cluster sums handed from front to back
    typedef struct packed {
        logic [ESUM_W-1:0]        esum;
        logic signed [WSUM_W-1:0] wsum_x;
        logic signed [WSUM_W-1:0] wsum_y;
        logic signed [15:0]       peak_x;
        logic signed [15:0]       peak_y;
        logic [6:0]               peak_row;
        logic signed [15:0]       x_least;
        logic signed [15:0]       x_greatest;
        logic signed [15:0]       y_least;
        logic signed [15:0]       y_greatest;
    } cluster_t;

    localparam cfg_t CFG_RESET = '{
        x_low:         -16'sd17500,
        x_high:        16'sd17500,
        y_low:         -16'sd7500,
        y_high:        16'sd7500,
        x_bin_count:   5'd10,
        y_bin_count:   5'd5,
        block_width_x: 16'd430,
        block_width_y: 16'd430
    };

endpackage

/* rtl/ccm_front.sv */
// Hit accumulator: sums energy and weighted positions, tracks peak and extent.
// Depends on ccm_pkg; pushes one cluster_t per cluster into ccm_queue.
module ccm_front #(
    parameter int MAX_HITS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ccm_pkg::hit_t     s_data,
    input  logic              q_full,
    output logic              q_push,
    output ccm_pkg::cluster_t q_data
);

    localparam int CNT_W = $clog2(MAX_HITS + 1);
    localparam int EW    = ccm_pkg::ESUM_W;
    localparam int WW    = ccm_pkg::WSUM_W;
    localparam int ES_W  = EW + 1;

    ccm_pkg::cluster_t clu_reg, clu_next, upd;
    logic [15:0]       peak_e_reg, peak_e_next;
    logic [CNT_W-1:0]  hits_reg, hits_next;

    logic              accept, take, first;
    logic [ES_W-1:0]   esum_sum;
    logic signed [32:0] px, py;
    logic signed [WW:0] wx_sum, wy_sum;

    always_comb begin
        s_ready  = !q_full;
        accept   = s_valid && s_ready;
        take     = hits_reg < CNT_W'(MAX_HITS);
        first    = hits_reg == '0;
        esum_sum = {1'b0, clu_reg.esum} + ES_W'(s_data.hit_energy);
        px       = s_data.hit_x * $signed({1'b0, s_data.hit_energy});
        py       = s_data.hit_y * $signed({1'b0, s_data.hit_energy});
        wx_sum   = $signed({clu_reg.wsum_x[WW-1], clu_reg.wsum_x}) + px;
        wy_sum   = $signed({clu_reg.wsum_y[WW-1], clu_reg.wsum_y}) + py;

        upd         = clu_reg;
        peak_e_next = peak_e_reg;
        hits_next   = hits_reg;
        if (take) begin
            upd.esum = esum_sum[EW] ? {EW{1'b1}} : esum_sum[EW-1:0];
            if (wx_sum[WW] != wx_sum[WW-1]) begin
                upd.wsum_x = wx_sum[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
            end else begin
                upd.wsum_x = wx_sum[WW-1:0];
            end
            if (wy_sum[WW] != wy_sum[WW-1]) begin
                upd.wsum_y = wy_sum[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
            end else begin
                upd.wsum_y = wy_sum[WW-1:0];
            end
            if (first || s_data.hit_energy > peak_e_reg) begin
                peak_e_next  = s_data.hit_energy;
                upd.peak_x   = s_data.hit_x;
                upd.peak_y   = s_data.hit_y;
                upd.peak_row = s_data.hit_row;
            end
            if (first || s_data.hit_x < clu_reg.x_least)    upd.x_least    = s_data.hit_x;
            if (first || s_data.hit_x > clu_reg.x_greatest) upd.x_greatest = s_data.hit_x;
            if (first || s_data.hit_y < clu_reg.y_least)    upd.y_least    = s_data.hit_y;
            if (first || s_data.hit_y > clu_reg.y_greatest) upd.y_greatest = s_data.hit_y;
            hits_next = hits_reg + 1'b1;
        end

        clu_next = upd;
        if (s_data.last_hit) begin
            clu_next  = '0;
            hits_next = '0;
        end

        q_push  = accept && s_data.last_hit;
        q_data  = upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clu_reg    <= '0;
            peak_e_reg <= '0;
            hits_reg   <= '0;
        end else if (accept) begin
            clu_reg    <= clu_next;
            peak_e_reg <= peak_e_next;
            hits_reg   <= hits_next;
        end
    end

endmodule

/* rtl/ccm_queue.sv */
// Short cluster queue between accumulator front and divider back.
// Depends on ccm_pkg (cluster_t, QUEUE_DEPTH).
module ccm_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ccm_pkg::cluster_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output ccm_pkg::cluster_t head
);

    localparam int QD    = ccm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int CNT_W = $clog2(QD + 1);

    ccm_pkg::cluster_t entry_reg [QD];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full  = count_reg == CNT_W'(QD);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < CNT_W'(QD)))
        else $error("cluster queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("cluster queue read while empty");

endmodule

/* rtl/ccm_div.sv */
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
// Depends on ccm_pkg (NUM_W, DEN_W, QUO_W).
module ccm_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ccm_pkg::NUM_W-1:0]  num,
    input  logic [ccm_pkg::DEN_W-1:0]  den,
    output logic                       done,
    output logic [ccm_pkg::QUO_W-1:0]  quo,
    output logic                       ovf
);

    localparam int NW = ccm_pkg::NUM_W;
    localparam int DW = ccm_pkg::DEN_W;
    localparam int QW = ccm_pkg::QUO_W;
    localparam int CW = $clog2(QW);
    localparam int HW = NW - QW;

    localparam logic [1:0] D_IDLE  = 2'd0;
    localparam logic [1:0] D_CHECK = 2'd1;
    localparam logic [1:0] D_RUN   = 2'd2;

    logic [1:0]    state_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg, rem_reg, high_part;
    logic [QW-1:0] low_reg, quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          ovf_reg, done_reg;
    logic [DW+1:0] diff;

    assign high_part = {{(DW - HW){1'b0}}, num_reg[NW-1:QW]};
    assign diff      = {1'b0, rem_reg, low_reg[QW-1]} - {2'b00, den_reg};
    assign done      = done_reg;
    assign quo       = quo_reg;
    assign ovf       = ovf_reg;

    always_ff @(posedge aclk) begin
        case (state_reg)
            D_IDLE: begin
                if (start) begin
                    num_reg <= num;
                    den_reg <= den;
                end
            end
            D_CHECK: begin
                ovf_reg <= high_part >= den_reg;
                rem_reg <= high_part;
                low_reg <= num_reg[QW-1:0];
                cnt_reg <= '0;
            end
            D_RUN: begin
                quo_reg <= {quo_reg[QW-2:0], !diff[DW+1]};
                if (!diff[DW+1]) begin
                    rem_reg <= diff[DW-1:0];
                end else begin
                    rem_reg <= {rem_reg[DW-2:0], low_reg[QW-1]};
                end
                low_reg <= {low_reg[QW-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == D_RUN) && (cnt_reg == CW'(QW - 1));
            unique case (state_reg)
                D_IDLE:  if (start) state_reg <= D_CHECK;
                D_CHECK: state_reg <= D_RUN;
                D_RUN: begin
                    if (cnt_reg == CW'(QW - 1)) begin
                        state_reg <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

endmodule

/* rtl/ccm_back.sv */
// Cluster finisher: moments, position bins and status through one shared divider.
// Depends on ccm_pkg and ccm_div; holds the result output register.
module ccm_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  ccm_pkg::cfg_t     cfg,
    input  logic              q_empty,
    input  ccm_pkg::cluster_t q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output ccm_pkg::result_t  m_data
);

    localparam int NW = ccm_pkg::NUM_W;
    localparam int DW = ccm_pkg::DEN_W;
    localparam int QW = ccm_pkg::QUO_W;
    localparam int RS = ccm_pkg::ROUND_SHIFT;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUB  = 3'd2;
    localparam logic [2:0] S_ABS  = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam logic [1:0] OP_XM = 2'd0;
    localparam logic [1:0] OP_YM = 2'd1;
    localparam logic [1:0] OP_XB = 2'd2;
    localparam logic [1:0] OP_YB = 2'd3;

    localparam logic [QW-1:0] MOM_POS_MAX = QW'(32767);
    localparam logic [QW-1:0] MOM_NEG_MAX = QW'(32768);

    logic [2:0]         state_reg;
    logic [1:0]         op_reg;
    ccm_pkg::cluster_t  job_reg;

    logic signed [38:0] prod_x_reg, prod_y_reg, num_x_reg, num_y_reg;
    logic [38:0]        den_x_reg, den_y_reg;
    logic [37:0]        mag_x_reg, mag_y_reg;
    logic               neg_x_reg, neg_y_reg;
    logic [20:0]        bnum_x_reg, bnum_y_reg;
    logic [15:0]        brange_x_reg, brange_y_reg;
    logic               bok_x_reg, bok_y_reg, span_x_reg, span_y_reg, row_ok_reg, zero_reg;
    logic [15:0]        xm_reg, ym_reg;
    logic [3:0]         bx_reg, by_reg;

    logic               m_valid_reg;
    ccm_pkg::result_t   m_data_reg;

    logic [16:0]        pitch_x, pitch_y;
    logic signed [16:0] dx, dy, rx, ry, sx, sy;
    logic               bok_x, bok_y;
    logic signed [38:0] neg_num_x, neg_num_y;

    logic               div_start, div_done, div_ovf;
    logic [NW-1:0]      div_num;
    logic [DW-1:0]      div_den;
    logic [QW-1:0]      div_quo;
    logic               op_neg;
    logic [15:0]        mom_val;
    logic [QW-1:0]      neg_quo;
    logic [8:0]         cell_sum;
    logic               out_free;
    ccm_pkg::result_t   res;

    ccm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo),
        .ovf     (div_ovf)
    );

    always_comb begin
        pitch_x = (cfg.block_width_x == '0) ? 17'h10000 : {1'b0, cfg.block_width_x};
        pitch_y = (cfg.block_width_y == '0) ? 17'h10000 : {1'b0, cfg.block_width_y};
        dx = $signed({job_reg.peak_x[15], job_reg.peak_x}) - $signed({cfg.x_low[15], cfg.x_low});
        dy = $signed({job_reg.peak_y[15], job_reg.peak_y}) - $signed({cfg.y_low[15], cfg.y_low});
        rx = $signed({cfg.x_high[15], cfg.x_high}) - $signed({cfg.x_low[15], cfg.x_low});
        ry = $signed({cfg.y_high[15], cfg.y_high}) - $signed({cfg.y_low[15], cfg.y_low});
        sx = $signed({job_reg.x_greatest[15], job_reg.x_greatest})
           - $signed({job_reg.x_least[15], job_reg.x_least});
        sy = $signed({job_reg.y_greatest[15], job_reg.y_greatest})
           - $signed({job_reg.y_least[15], job_reg.y_least});
        bok_x = (cfg.x_bin_count != '0) && (cfg.x_bin_count <= 5'(ccm_pkg::BIN_LIMIT))
             && (rx > 17'sd0) && (dx >= 17'sd0) && (dx < rx);
        bok_y = (cfg.y_bin_count != '0) && (cfg.y_bin_count <= 5'(ccm_pkg::BIN_LIMIT))
             && (ry > 17'sd0) && (dy >= 17'sd0) && (dy < ry);
        neg_num_x = -num_x_reg;
        neg_num_y = -num_y_reg;

        div_start = state_reg == S_LOAD;
        case (op_reg)
            OP_XM: begin
                div_num = NW'({mag_x_reg, {RS{1'b0}}}) + NW'(den_x_reg);
                div_den = {den_x_reg, 1'b0};
            end
            OP_YM: begin
                div_num = NW'({mag_y_reg, {RS{1'b0}}}) + NW'(den_y_reg);
                div_den = {den_y_reg, 1'b0};
            end
            OP_XB: begin
                div_num = NW'(bnum_x_reg);
                div_den = DW'(brange_x_reg);
            end
            default: begin
                div_num = NW'(bnum_y_reg);
                div_den = DW'(brange_y_reg);
            end
        endcase

        // round half away from zero already folded into the dividend
        op_neg  = (op_reg == OP_XM) ? neg_x_reg : neg_y_reg;
        neg_quo = -div_quo;
        if (op_neg) begin
            mom_val = (div_ovf || div_quo > MOM_NEG_MAX) ? 16'h8000 : neg_quo[15:0];
        end else begin
            mom_val = (div_ovf || div_quo > MOM_POS_MAX) ? 16'h7FFF : div_quo[15:0];
        end

        cell_sum = 9'(by_reg) + 9'(bx_reg) * 9'(cfg.y_bin_count);
        res.cell_bin = (bok_x_reg && bok_y_reg) ? cell_sum[7:0] : 8'd0;
        res.x_moment = zero_reg ? 16'sd0 : $signed(xm_reg);
        res.y_moment = zero_reg ? 16'sd0 : $signed(ym_reg);
        if (zero_reg) begin
            res.status = ccm_pkg::ST_ZERO;
        end else if (!span_x_reg || !span_y_reg || !row_ok_reg) begin
            res.status = ccm_pkg::ST_REJECT;
        end else if (!(bok_x_reg && bok_y_reg)) begin
            res.status = ccm_pkg::ST_RANGE;
        end else begin
            res.status = ccm_pkg::ST_ACCEPT;
        end

        out_free = !m_valid_reg || m_ready;
        q_pop    = (state_reg == S_IDLE) && !q_empty;
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (q_pop) job_reg <= q_head;
            end
            S_MUL: begin
                prod_x_reg   <= job_reg.peak_x * $signed({1'b0, job_reg.esum});
                prod_y_reg   <= job_reg.peak_y * $signed({1'b0, job_reg.esum});
                den_x_reg    <= 39'(job_reg.esum) * 39'(pitch_x);
                den_y_reg    <= 39'(job_reg.esum) * 39'(pitch_y);
                bnum_x_reg   <= 21'(dx[15:0]) * 21'(cfg.x_bin_count);
                bnum_y_reg   <= 21'(dy[15:0]) * 21'(cfg.y_bin_count);
                brange_x_reg <= rx[15:0];
                brange_y_reg <= ry[15:0];
                bok_x_reg    <= bok_x;
                bok_y_reg    <= bok_y;
                span_x_reg   <= $signed({sx[16], sx, 1'b0}) > $signed({2'b00, pitch_x});
                span_y_reg   <= $signed({sy[16], sy, 1'b0}) > $signed({2'b00, pitch_y});
                row_ok_reg   <= (job_reg.peak_row != '0)
                             && (job_reg.peak_row < 7'(ccm_pkg::ROW_LIMIT));
                zero_reg     <= job_reg.esum == '0;
            end
            S_SUB: begin
                num_x_reg <= $signed({job_reg.wsum_x[37], job_reg.wsum_x}) - prod_x_reg;
                num_y_reg <= $signed({job_reg.wsum_y[37], job_reg.wsum_y}) - prod_y_reg;
            end
            S_ABS: begin
                neg_x_reg <= num_x_reg[38];
                neg_y_reg <= num_y_reg[38];
                mag_x_reg <= num_x_reg[38] ? neg_num_x[37:0] : num_x_reg[37:0];
                mag_y_reg <= num_y_reg[38] ? neg_num_y[37:0] : num_y_reg[37:0];
            end
            S_WAIT: begin
                if (div_done) begin
                    case (op_reg)
                        OP_XM:   xm_reg <= mom_val;
                        OP_YM:   ym_reg <= mom_val;
                        OP_XB:   bx_reg <= div_quo[3:0];
                        default: by_reg <= div_quo[3:0];
                    endcase
                end
            end
            default: ;
        endcase
        if (state_reg == S_FIN && out_free) begin
            m_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_XM;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: if (q_pop) state_reg <= S_MUL;
                S_MUL:  state_reg <= S_SUB;
                S_SUB:  state_reg <= S_ABS;
                S_ABS: begin
                    op_reg    <= OP_XM;
                    state_reg <= S_LOAD;
                end
                S_LOAD: state_reg <= S_WAIT;
                S_WAIT: begin
                    if (div_done) begin
                        if (op_reg == OP_YB) begin
                            state_reg <= S_FIN;
                        end else begin
                            op_reg    <= op_reg + 1'b1;
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_WAIT))
        else $error("divider finished outside of wait state");

    a_div_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> !div_done)
        else $error("divider finished one cycle after start");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && m_valid_reg && !m_ready) |=> (state_reg == S_FIN && m_valid_reg))
        else $error("finished cluster dropped while output stalled");

endmodule

/* rtl/cluster_centroid_moment_core.sv */
// Energy-weighted cluster centroid core. The front takes one hit per cycle; after
// the hit marked last, the cluster's sums go into a two-entry queue and the back
// finishes them: four divisions (x and y moment, x and y bin) share one restoring
// divider at one quotient bit per cycle. Clusters that arrive faster than the back
// finishes them fill the queue, and the hit input then waits until a queue entry
// frees. Depends on ccm_pkg, ccm_front, ccm_queue, ccm_div and ccm_back.
module cluster_centroid_moment_core #(
    parameter int MAX_HITS = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ccm_pkg::hit_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ccm_pkg::result_t m_data,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_wr_index,
    input  logic [15:0]      cfg_wr_data
);

    ccm_pkg::cfg_t     cfg_reg;
    ccm_pkg::cluster_t push_data, head;
    logic              push, pop, full, empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= ccm_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                ccm_pkg::REG_X_LOW:         cfg_reg.x_low         <= cfg_wr_data;
                ccm_pkg::REG_X_HIGH:        cfg_reg.x_high        <= cfg_wr_data;
                ccm_pkg::REG_Y_LOW:         cfg_reg.y_low         <= cfg_wr_data;
                ccm_pkg::REG_Y_HIGH:        cfg_reg.y_high        <= cfg_wr_data;
                ccm_pkg::REG_X_BIN_COUNT:   cfg_reg.x_bin_count   <= cfg_wr_data[4:0];
                ccm_pkg::REG_Y_BIN_COUNT:   cfg_reg.y_bin_count   <= cfg_wr_data[4:0];
                ccm_pkg::REG_BLOCK_WIDTH_X: cfg_reg.block_width_x <= cfg_wr_data;
                ccm_pkg::REG_BLOCK_WIDTH_Y: cfg_reg.block_width_y <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    ccm_front #(
        .MAX_HITS (MAX_HITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (full),
        .q_push  (push),
        .q_data  (push_data)
    );

    ccm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    ccm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (empty),
        .q_head  (head),
        .q_pop   (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
